// ===== rtl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and codes of the JSON string escaper: the word that the
// front passes to the back through the queue.
// ----------------------------------------------------------------------------
package jse_pkg;

	// what follows the held bytes in one word
	localparam logic [2:0] TK_NONE  = 3'd0; // nothing
	localparam logic [2:0] TK_RAW   = 3'd1; // tail_byte as it is
	localparam logic [2:0] TK_ESC2  = 3'd2; // backslash, then tail_byte
	localparam logic [2:0] TK_HEX   = 3'd3; // \u00xx of tail_byte
	localparam logic [2:0] TK_CLOSE = 3'd4; // closing quote

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	// one word of work for the back end, emitted in this order:
	// opening quote, flush_n hex escapes of data[], pass_n raw bytes of data[], tail
	typedef struct packed {
		logic            open_quote;
		logic [1:0]      flush_n;
		logic [2:0]      pass_n;
		logic [3:0][7:0] data;
		logic [2:0]      tail_kind;
		logic [7:0]      tail_byte;
	} jse_desc_t;

endpackage

// ===== rtl/jse_front.sv =====
// ----------------------------------------------------------------------------
// jse_front
// Accepts string bytes and end marks, tracks the UTF-8 prefix being held and
// classifies each item into at most one work word for the back end.
// ----------------------------------------------------------------------------
module jse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                q_full,
	input  logic                cmd,
	input  logic [7:0]          data_byte,
	output logic                desc_push,
	output jse_pkg::jse_desc_t  desc
);
	import jse_pkg::*;

	logic            inside_q;
	logic [7:0]      held_q [3];
	logic [1:0]      hcnt_q;
	logic [2:0]      slen_q;

	logic            accept;
	logic            cont;
	logic            fresh;
	logic            hold_we;
	logic [1:0]      hold_idx;
	logic [1:0]      nxt_hcnt;
	logic [2:0]      nxt_slen;
	logic [2:0]      hcnt_inc;

	assign accept   = push & ~q_full;
	assign hcnt_inc = {1'b0, hcnt_q} + 3'd1;

	// continuation byte check, with the narrowed ranges after E0, ED, F0, F4
	always_comb begin
		cont = data_byte inside {[8'h80:8'hbf]};
		if (hcnt_q == 2'd1) begin
			if (held_q[0] == 8'he0 && data_byte < 8'ha0) cont = 1'b0;
			if (held_q[0] == 8'hed && data_byte > 8'h9f) cont = 1'b0;
			if (held_q[0] == 8'hf0 && data_byte < 8'h90) cont = 1'b0;
			if (held_q[0] == 8'hf4 && data_byte > 8'h8f) cont = 1'b0;
		end
	end

	always_comb begin
		desc            = '0;
		desc.open_quote = ~inside_q;
		desc.data[0]    = held_q[0];
		desc.data[1]    = held_q[1];
		desc.data[2]    = held_q[2];
		desc.tail_kind  = TK_NONE;
		desc.tail_byte  = data_byte;
		nxt_hcnt        = hcnt_q;
		nxt_slen        = slen_q;
		hold_we         = 1'b0;
		hold_idx        = hcnt_q;
		fresh           = 1'b0;

		if (cmd) begin
			desc.flush_n   = hcnt_q;
			desc.tail_kind = TK_CLOSE;
			nxt_hcnt       = 2'd0;
			nxt_slen       = 3'd0;
		end else if (hcnt_q != 2'd0) begin
			if (cont && hcnt_inc == slen_q) begin
				// sequence complete: pass it whole
				desc.pass_n         = hcnt_inc;
				desc.data[hcnt_q]   = data_byte;
				nxt_hcnt            = 2'd0;
				nxt_slen            = 3'd0;
			end else if (cont) begin
				hold_we  = 1'b1;
				nxt_hcnt = hcnt_q + 2'd1;
			end else begin
				// broken prefix: escape what is held, then take the byte fresh
				desc.flush_n = hcnt_q;
				nxt_hcnt     = 2'd0;
				nxt_slen     = 3'd0;
				fresh        = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end

		if (fresh) begin
			case (data_byte)
				CH_QUOTE: begin
					desc.tail_kind = TK_ESC2;
				end
				CH_BSLASH: begin
					desc.tail_kind = TK_ESC2;
				end
				8'h08: begin
					desc.tail_kind = TK_ESC2;
					desc.tail_byte = 8'h62;
				end
				8'h0c: begin
					desc.tail_kind = TK_ESC2;
					desc.tail_byte = 8'h66;
				end
				8'h0a: begin
					desc.tail_kind = TK_ESC2;
					desc.tail_byte = 8'h6e;
				end
				8'h0d: begin
					desc.tail_kind = TK_ESC2;
					desc.tail_byte = 8'h72;
				end
				8'h09: begin
					desc.tail_kind = TK_ESC2;
					desc.tail_byte = 8'h74;
				end
				default: begin
					if (data_byte < 8'h20) begin
						desc.tail_kind = TK_HEX;
					end else if (data_byte < 8'h80) begin
						desc.tail_kind = TK_RAW;
					end else if (data_byte inside {[8'hc2:8'hdf]}) begin
						hold_we  = 1'b1;
						hold_idx = 2'd0;
						nxt_hcnt = 2'd1;
						nxt_slen = 3'd2;
					end else if (data_byte inside {[8'he0:8'hef]}) begin
						hold_we  = 1'b1;
						hold_idx = 2'd0;
						nxt_hcnt = 2'd1;
						nxt_slen = 3'd3;
					end else if (data_byte inside {[8'hf0:8'hf4]}) begin
						hold_we  = 1'b1;
						hold_idx = 2'd0;
						nxt_hcnt = 2'd1;
						nxt_slen = 3'd4;
					end else begin
						desc.tail_kind = TK_HEX;
					end
				end
			endcase
		end
	end

	// a byte that only extends a prefix produces no word
	assign desc_push = accept & (desc.open_quote | (desc.flush_n != 2'd0) |
		(desc.pass_n != 3'd0) | (desc.tail_kind != TK_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			hcnt_q   <= 2'd0;
			slen_q   <= 3'd0;
		end else if (accept) begin
			inside_q <= ~cmd;
			hcnt_q   <= nxt_hcnt;
			slen_q   <= nxt_slen;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_we) begin
			held_q[hold_idx] <= data_byte;
		end
	end

	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q != 2'd0 |-> ({1'b0, hcnt_q} < slen_q) && inside_q)
		else $error("held count not below sequence length");

	a_len_clear: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q == 2'd0 |-> slen_q == 3'd0)
		else $error("sequence length left set with nothing held");

endmodule

// ===== rtl/jse_fifo.sv =====
// ----------------------------------------------------------------------------
// jse_fifo
// Short queue of work words between the front and the back end.
// ----------------------------------------------------------------------------
module jse_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  jse_pkg::jse_desc_t  wdata,
	output logic                full,
	input  logic                rd,
	output jse_pkg::jse_desc_t  rdata,
	output logic                head_valid
);
	import jse_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	jse_desc_t      mem [DEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CW-1:0]  cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign rdata      = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/jse_back.sv =====
// ----------------------------------------------------------------------------
// jse_back
// Expands the word at the head of the queue into output bytes, one byte per
// pop: opening quote, hex escapes of a broken prefix, passed UTF-8 bytes, tail.
// ----------------------------------------------------------------------------
module jse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  jse_pkg::jse_desc_t  desc,
	input  logic                pop,
	output logic [7:0]          out_byte,
	output logic                last_of_run,
	output logic                deq
);
	import jse_pkg::*;

	localparam logic [2:0] PH_OPEN  = 3'd0;
	localparam logic [2:0] PH_FLUSH = 3'd1;
	localparam logic [2:0] PH_PASS  = 3'd2;
	localparam logic [2:0] PH_TAIL  = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	localparam logic [2:0] DIG_LAST = 3'd5;

	logic [2:0] phase_q;
	logic [1:0] idx_q;
	logic [2:0] dig_q;

	logic [2:0] eff;
	logic [2:0] after;
	logic [2:0] tail_len;
	logic       sec_end;
	logic       step;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'b0, n}) : (8'h57 + {4'b0, n});
	endfunction

	// \ u 0 0 hi lo
	function automatic logic [7:0] hex_esc(input logic [7:0] b, input logic [2:0] dig);
		logic [7:0] c;
		case (dig)
			3'd0:    c = CH_BSLASH;
			3'd1:    c = 8'h75;
			3'd2:    c = 8'h30;
			3'd3:    c = 8'h30;
			3'd4:    c = hex_char(b[7:4]);
			default: c = hex_char(b[3:0]);
		endcase
		return c;
	endfunction

	// first section at or after p that has anything to send
	function automatic logic [2:0] first_from(input jse_desc_t d, input logic [2:0] p);
		logic [2:0] r;
		r = PH_DONE;
		if (p <= PH_TAIL && d.tail_kind != TK_NONE) r = PH_TAIL;
		if (p <= PH_PASS && d.pass_n != 3'd0) r = PH_PASS;
		if (p <= PH_FLUSH && d.flush_n != 2'd0) r = PH_FLUSH;
		if (p == PH_OPEN && d.open_quote) r = PH_OPEN;
		return r;
	endfunction

	assign eff   = first_from(desc, phase_q);
	assign after = (eff == PH_DONE) ? PH_DONE : first_from(desc, eff + 3'd1);

	always_comb begin
		case (desc.tail_kind)
			TK_ESC2: tail_len = 3'd2;
			TK_HEX:  tail_len = 3'd6;
			default: tail_len = 3'd1;
		endcase
	end

	always_comb begin
		case (eff)
			PH_OPEN:  sec_end = 1'b1;
			PH_FLUSH: sec_end = (dig_q == DIG_LAST) && (idx_q == desc.flush_n - 2'd1);
			PH_PASS:  sec_end = ({1'b0, idx_q} == desc.pass_n - 3'd1);
			PH_TAIL:  sec_end = (dig_q == tail_len - 3'd1);
			default:  sec_end = 1'b1;
		endcase
	end

	assign last_of_run = sec_end && (after == PH_DONE);
	assign step        = head_valid & pop;
	assign deq         = step & last_of_run;

	always_comb begin
		case (eff)
			PH_OPEN:  out_byte = CH_QUOTE;
			PH_FLUSH: out_byte = hex_esc(desc.data[idx_q], dig_q);
			PH_PASS:  out_byte = desc.data[idx_q];
			PH_TAIL: begin
				case (desc.tail_kind)
					TK_RAW:  out_byte = desc.tail_byte;
					TK_ESC2: out_byte = (dig_q == 3'd0) ? CH_BSLASH : desc.tail_byte;
					TK_HEX:  out_byte = hex_esc(desc.tail_byte, dig_q);
					default: out_byte = CH_QUOTE;
				endcase
			end
			default:  out_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			idx_q   <= 2'd0;
			dig_q   <= 3'd0;
		end else if (step) begin
			if (last_of_run) begin
				phase_q <= PH_OPEN;
				idx_q   <= 2'd0;
				dig_q   <= 3'd0;
			end else if (sec_end) begin
				phase_q <= eff + 3'd1;
				idx_q   <= 2'd0;
				dig_q   <= 3'd0;
			end else if (eff == PH_FLUSH) begin
				if (dig_q == DIG_LAST) begin
					dig_q <= 3'd0;
					idx_q <= idx_q + 2'd1;
				end else begin
					dig_q <= dig_q + 3'd1;
				end
			end else if (eff == PH_PASS) begin
				idx_q <= idx_q + 2'd1;
			end else begin
				dig_q <= dig_q + 3'd1;
			end
		end
	end

	a_word_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> eff != PH_DONE)
		else $error("queued word has nothing to send");

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> phase_q == PH_OPEN && idx_q == 2'd0 && dig_q == 3'd0)
		else $error("back end counters not rewound between words");

endmodule

// ===== rtl/json_string_escaper_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_escaper_utf8
// Escapes a byte stream into a quoted JSON string, passing well-formed UTF-8
// through and escaping malformed bytes as \u00xx.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------
//  input    | push / full         | cmd, data_byte
//  result   | empty / pop         | out_byte, last_of_run
//
// An input word is taken in the cycle it is pushed while the internal queue
// has room; the front classifies it at once and stalls only when the queue
// is full. The back end sends one result byte per pop, so an input byte
// yields 0 to 24 result bytes (none for a byte that only extends a held
// prefix, 1 for plain text, 6 per \u00xx escape); with pop held, the back end's
// one-byte-per-cycle output sets the sustained rate.
// arst_n clears the string state, the queue and the expansion counters.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8 #(
	parameter int QDEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_of_run
);
	import jse_pkg::*;

	jse_desc_t desc_in;
	jse_desc_t desc_head;
	logic      desc_push;
	logic      head_valid;
	logic      deq;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (full),
		.cmd       (cmd),
		.data_byte (data_byte),
		.desc_push (desc_push),
		.desc      (desc_in)
	);

	jse_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (desc_push),
		.wdata      (desc_in),
		.full       (full),
		.rd         (deq),
		.rdata      (desc_head),
		.head_valid (head_valid)
	);

	jse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.desc        (desc_head),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.deq         (deq)
	);

	assign empty = ~head_valid;

endmodule
